FILE: rtl/core/esc_pkg.sv
package esc_pkg;

    localparam int unsigned CfgIdxW = 3;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_TEMP_CAL       = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_LO   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_HI   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_CAL_LAST = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM_CAL        = 3'd4;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    // Fields that ride along with an item through the divider
    typedef struct packed {
        logic [23:0] temp;
        logic [16:0] hum;
        logic        inv;
        logic        dbl;
    } esc_side_t;

    // Low 32 bits of a 32x32 product
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    // Arithmetic right shift of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

FILE: rtl/core/esc_div.sv
module esc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic [31:0]        in_dvd,
    input  logic [31:0]        in_dvs,
    input  esc_pkg::esc_side_t in_side,
    output logic               out_vld,
    output logic [31:0]        out_quo,
    output esc_pkg::esc_side_t out_side
);
    import esc_pkg::*;

    localparam int unsigned Steps = 32;

    logic [31:0] rem_reg [1:Steps];
    logic [31:0] dvd_reg [1:Steps];
    logic [31:0] quo_reg [1:Steps];
    logic [31:0] dvs_reg [1:Steps];
    esc_side_t   side_reg [1:Steps];
    logic [Steps:1] vld_reg;

    logic [31:0] rem_in [1:Steps];
    logic [31:0] dvd_in [1:Steps];
    logic [31:0] quo_in [1:Steps];
    logic [31:0] dvs_in [1:Steps];
    esc_side_t   side_in [1:Steps];
    logic [Steps:1] vld_in;

    // One quotient bit per stage, restoring form
    for (genvar k = 1; k <= Steps; k++) begin : g_step
        logic [32:0] trial;
        logic        fit;

        if (k == 1) begin : g_first
            assign rem_in[k]  = '0;
            assign dvd_in[k]  = in_dvd;
            assign quo_in[k]  = '0;
            assign dvs_in[k]  = in_dvs;
            assign side_in[k] = in_side;
            assign vld_in[k]  = in_vld;
        end else begin : g_next
            assign rem_in[k]  = rem_reg[k-1];
            assign dvd_in[k]  = dvd_reg[k-1];
            assign quo_in[k]  = quo_reg[k-1];
            assign dvs_in[k]  = dvs_reg[k-1];
            assign side_in[k] = side_reg[k-1];
            assign vld_in[k]  = vld_reg[k-1];
        end

        assign trial = {rem_in[k], dvd_in[k][31]};
        assign fit   = trial >= {1'b0, dvs_in[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fit ? 32'(trial - {1'b0, dvs_in[k]}) : trial[31:0];
                dvd_reg[k]  <= {dvd_in[k][30:0], 1'b0};
                quo_reg[k]  <= {quo_in[k][30:0], fit};
                dvs_reg[k]  <= dvs_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_vld  = vld_reg[Steps];
    assign out_quo  = quo_reg[Steps];
    assign out_side = side_reg[Steps];

endmodule

FILE: rtl/core/env_sensor_compensation.sv
// Compensates one raw reading per clock while no stall holds it: temperature
// first (fine value), then pressure and humidity from it, using the integer
// 32-bit formulas with wrap. An item enters each cycle that s_tready is high;
// it passes 13 arithmetic stages, a 32-stage one-bit-per-stage pressure
// divider and 2 correction stages plus the output register. A low m_tready
// with a result waiting stalls the whole pipeline in place. m_tuser is set
// when the pressure divisor is zero; pressure then reads 0. The user must write
// calibration words through the cfg port while the block is idle; it does not check.
module env_sensor_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // temp_centi[23:0], press_pa[55:24], hum_q10[72:56]
    output logic [0:0]  m_tuser,  // press_invalid[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [esc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    import esc_pkg::*;

    logic [47:0] temp_cal_reg;
    logic [63:0] pcal_lo_reg;
    logic [63:0] pcal_hi_reg;
    logic [15:0] pcal_last_reg;
    logic [63:0] hum_cal_reg;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    logic        adv;
    logic [13:1] vld_reg;

    // Write calibration words
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cal_reg  <= '0;
            pcal_lo_reg   <= '0;
            pcal_hi_reg   <= '0;
            pcal_last_reg <= '0;
            hum_cal_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TEMP_CAL:       temp_cal_reg  <= cfg_data[47:0];
                REG_PRESS_CAL_LO:   pcal_lo_reg   <= cfg_data;
                REG_PRESS_CAL_HI:   pcal_hi_reg   <= cfg_data;
                REG_PRESS_CAL_LAST: pcal_last_reg <= cfg_data[15:0];
                REG_HUM_CAL:        hum_cal_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    assign t1 = {16'd0, temp_cal_reg[15:0]};
    assign t2 = sx16(temp_cal_reg[31:16]);
    assign t3 = sx16(temp_cal_reg[47:32]);
    assign p1 = {16'd0, pcal_lo_reg[15:0]};
    assign p2 = sx16(pcal_lo_reg[31:16]);
    assign p3 = sx16(pcal_lo_reg[47:32]);
    assign p4 = sx16(pcal_lo_reg[63:48]);
    assign p5 = sx16(pcal_hi_reg[15:0]);
    assign p6 = sx16(pcal_hi_reg[31:16]);
    assign p7 = sx16(pcal_hi_reg[47:32]);
    assign p8 = sx16(pcal_hi_reg[63:48]);
    assign p9 = sx16(pcal_last_reg);
    assign h1 = {24'd0, hum_cal_reg[7:0]};
    assign h2 = sx16(hum_cal_reg[23:8]);
    assign h3 = {24'd0, hum_cal_reg[31:24]};
    assign h4 = sx12(hum_cal_reg[43:32]);
    assign h5 = sx12(hum_cal_reg[55:44]);
    assign h6 = sx8(hum_cal_reg[63:56]);

    logic        m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Advance stage valids
    logic dv_out;
    logic [2:1] pv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            pv_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[12:1], s_tvalid};
            pv_reg       <= {pv_reg[1], dv_out};
            m_tvalid_reg <= pv_reg[2];
        end
    end

    logic [31:0] adc_t, adc_p, adc_h, x1, xd;
    assign adc_t = {12'd0, s_tdata[19:0]};
    assign adc_p = {12'd0, s_tdata[39:20]};
    assign adc_h = {16'd0, s_tdata[55:40]};
    assign x1    = (adc_t >> 3) - (t1 << 1);
    assign xd    = (adc_t >> 4) - t1;

    logic [31:0] s1_ma_reg, s1_dd_reg, s1_adcp_reg, s1_adch_reg;
    logic [31:0] s2_a_reg, s2_mb_reg, s2_adcp_reg, s2_adch_reg;
    logic [31:0] s3_tf_reg, s3_adcp_reg, s3_adch_reg;
    logic [23:0] s4_temp_reg;
    logic [31:0] s4_pa_reg, s4_d_reg, s4_v_reg, s4_adcp_reg, s4_adch_reg;
    logic [23:0] s5_temp_reg;
    logic [31:0] s5_dd_reg, s5_m1_reg, s5_m2_reg, s5_hv5_reg, s5_vh6_reg, s5_vh3_reg;
    logic [31:0] s5_adcp_reg, s5_adch_reg;
    logic [23:0] s6_temp_reg;
    logic [31:0] s6_b_reg, s6_c_reg, s6_m1_reg, s6_m2_reg, s6_ha_reg, s6_hb_reg;
    logic [31:0] s6_adcp_reg;
    logic [23:0] s7_temp_reg;
    logic [31:0] s7_b2_reg, s7_a1_reg, s7_hb2_reg, s7_ha_reg, s7_adcp_reg;
    logic [23:0] s8_temp_reg;
    logic [31:0] s8_a2_reg, s8_pn_reg, s8_bh_reg, s8_ha_reg;
    logic [23:0] s9_temp_reg;
    logic [31:0] s9_dvs_reg, s9_hbb_reg, s9_pn_reg, s9_ha_reg;
    logic [23:0] s10_temp_reg;
    logic [31:0] s10_hv_reg, s10_dvs_reg, s10_pn_reg;
    logic [23:0] s11_temp_reg;
    logic [31:0] s11_sq_reg, s11_hv_reg, s11_dvs_reg, s11_pn_reg;
    logic [23:0] s12_temp_reg;
    logic [31:0] s12_t_reg, s12_hv_reg, s12_dvs_reg, s12_pn_reg;
    logic [31:0] s13_dvd_reg, s13_dvs_reg;
    esc_side_t   s13_side_reg;

    logic [31:0] tf_next, temp_next, pa_next, hum_v, hum_next;
    assign tf_next   = s2_a_reg + asr(s2_mb_reg, 5'd14);
    assign temp_next = asr(((s3_tf_reg << 2) + s3_tf_reg) + 32'd128, 5'd8);
    assign pa_next   = asr(s3_tf_reg, 5'd1) - 32'd64000;
    assign hum_v     = s12_hv_reg - asr(s12_t_reg, 5'd4);
    assign hum_next  = hum_v[31] ? 32'd0 : ((hum_v > HUM_MAX) ? HUM_MAX : hum_v);

    // Arithmetic stages; all hold together on a stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            // fine temperature products
            s1_ma_reg   <= mul32(x1, t2);
            s1_dd_reg   <= mul32(xd, xd);
            s1_adcp_reg <= adc_p;
            s1_adch_reg <= adc_h;
            s2_a_reg    <= asr(s1_ma_reg, 5'd11);
            s2_mb_reg   <= mul32(asr(s1_dd_reg, 5'd12), t3);
            s2_adcp_reg <= s1_adcp_reg;
            s2_adch_reg <= s1_adch_reg;
            s3_tf_reg   <= tf_next;
            s3_adcp_reg <= s2_adcp_reg;
            s3_adch_reg <= s2_adch_reg;
            // temperature result and pressure/humidity offsets
            s4_temp_reg <= temp_next[23:0];
            s4_pa_reg   <= pa_next;
            s4_d_reg    <= asr(pa_next, 5'd2);
            s4_v_reg    <= s3_tf_reg - 32'd76800;
            s4_adcp_reg <= s3_adcp_reg;
            s4_adch_reg <= s3_adch_reg;
            s5_temp_reg <= s4_temp_reg;
            s5_dd_reg   <= mul32(s4_d_reg, s4_d_reg);
            s5_m1_reg   <= mul32(s4_pa_reg, p5);
            s5_m2_reg   <= mul32(p2, s4_pa_reg);
            s5_hv5_reg  <= mul32(h5, s4_v_reg);
            s5_vh6_reg  <= mul32(s4_v_reg, h6);
            s5_vh3_reg  <= mul32(s4_v_reg, h3);
            s5_adcp_reg <= s4_adcp_reg;
            s5_adch_reg <= s4_adch_reg;
            s6_temp_reg <= s5_temp_reg;
            s6_b_reg    <= mul32(asr(s5_dd_reg, 5'd11), p6);
            s6_c_reg    <= mul32(p3, asr(s5_dd_reg, 5'd13));
            s6_m1_reg   <= s5_m1_reg;
            s6_m2_reg   <= s5_m2_reg;
            s6_ha_reg   <= asr(((s5_adch_reg << 14) - (h4 << 20) - s5_hv5_reg)
                               + 32'd16384, 5'd15);
            s6_hb_reg   <= mul32(asr(s5_vh6_reg, 5'd10),
                                 asr(s5_vh3_reg, 5'd11) + 32'd32768);
            s6_adcp_reg <= s5_adcp_reg;
            // pressure divisor and numerator terms
            s7_temp_reg <= s6_temp_reg;
            s7_b2_reg   <= asr(s6_b_reg + (s6_m1_reg << 1), 5'd2) + (p4 << 16);
            s7_a1_reg   <= asr(asr(s6_c_reg, 5'd3) + asr(s6_m2_reg, 5'd1), 5'd18);
            s7_hb2_reg  <= asr(s6_hb_reg, 5'd10) + 32'd2097152;
            s7_ha_reg   <= s6_ha_reg;
            s7_adcp_reg <= s6_adcp_reg;
            s8_temp_reg <= s7_temp_reg;
            s8_a2_reg   <= mul32(32'd32768 + s7_a1_reg, p1);
            s8_pn_reg   <= (32'd1048576 - s7_adcp_reg) - asr(s7_b2_reg, 5'd12);
            s8_bh_reg   <= mul32(s7_hb2_reg, h2);
            s8_ha_reg   <= s7_ha_reg;
            s9_temp_reg <= s8_temp_reg;
            s9_dvs_reg  <= asr(s8_a2_reg, 5'd15);
            s9_hbb_reg  <= asr(s8_bh_reg + 32'd8192, 5'd14);
            s9_pn_reg   <= mul32(s8_pn_reg, 32'd3125);
            s9_ha_reg   <= s8_ha_reg;
            // humidity tail
            s10_temp_reg <= s9_temp_reg;
            s10_hv_reg   <= mul32(s9_ha_reg, s9_hbb_reg);
            s10_dvs_reg  <= s9_dvs_reg;
            s10_pn_reg   <= s9_pn_reg;
            s11_temp_reg <= s10_temp_reg;
            s11_sq_reg   <= mul32(asr(s10_hv_reg, 5'd15), asr(s10_hv_reg, 5'd15));
            s11_hv_reg   <= s10_hv_reg;
            s11_dvs_reg  <= s10_dvs_reg;
            s11_pn_reg   <= s10_pn_reg;
            s12_temp_reg <= s11_temp_reg;
            s12_t_reg    <= mul32(asr(s11_sq_reg, 5'd7), h1);
            s12_hv_reg   <= s11_hv_reg;
            s12_dvs_reg  <= s11_dvs_reg;
            s12_pn_reg   <= s11_pn_reg;
            // divider operands
            s13_dvd_reg       <= s12_pn_reg[31] ? s12_pn_reg : (s12_pn_reg << 1);
            s13_dvs_reg       <= s12_dvs_reg;
            s13_side_reg.temp <= s12_temp_reg;
            s13_side_reg.hum  <= hum_next[28:12];
            s13_side_reg.inv  <= (s12_dvs_reg == 32'd0);
            s13_side_reg.dbl  <= s12_pn_reg[31];
        end
    end

    logic [31:0] dv_quo;
    esc_side_t   dv_side;

    esc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (vld_reg[13]),
        .in_dvd   (s13_dvd_reg),
        .in_dvs   (s13_dvs_reg),
        .in_side  (s13_side_reg),
        .out_vld  (dv_out),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // Pressure correction after the divide
    logic [31:0] pq;
    logic [31:0] p1_p_reg, p1_qq_reg, p1_pb_reg;
    esc_side_t   p1_side_reg;
    logic [31:0] p2_p_reg, p2_a9_reg, p2_pb_reg;
    esc_side_t   p2_side_reg;
    logic [31:0] press_fix;
    logic [79:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign pq        = dv_side.dbl ? (dv_quo << 1) : dv_quo;
    assign press_fix = p2_p_reg + asr(asr(p2_a9_reg, 5'd12) + asr(p2_pb_reg, 5'd13)
                                      + p7, 5'd4);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_p_reg    <= pq;
            p1_qq_reg   <= mul32(pq >> 3, pq >> 3);
            p1_pb_reg   <= mul32(pq >> 2, p8);
            p1_side_reg <= dv_side;
            p2_p_reg    <= p1_p_reg;
            p2_a9_reg   <= mul32(p9, p1_qq_reg >> 13);
            p2_pb_reg   <= p1_pb_reg;
            p2_side_reg <= p1_side_reg;
            m_tdata_reg <= {7'd0, p2_side_reg.hum,
                            p2_side_reg.inv ? 32'd0 : press_fix, p2_side_reg.temp};
            m_tuser_reg <= p2_side_reg.inv;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Invalid divisor always reports zero pressure
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[55:24] == 32'd0)
        else $error("invalid pressure not forced to zero");

    // Humidity stays within its clamp
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[72:56] <= 17'd102400)
        else $error("humidity out of range");

    // A stalled pipeline keeps its divider output in place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv && dv_out |=> dv_out && $stable(dv_quo))
        else $error("divider moved during stall");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import esc_pkg::*;

    typedef struct {
        logic [23:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
        logic        inv;
    } reading_t;

    localparam int WatchLimit = 3000;
    localparam int DrainCycles = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // calibration copy held by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_plo;
    logic [63:0] cal_phi;
    logic [15:0] cal_plast;
    logic [63:0] cal_hum;

    reading_t pending_readings[$];
    int errors = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    int quiet_cycles = 0;

    env_sensor_compensation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] sar(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] mlo(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    // compute the compensated reading from one raw item
    function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                            input logic [15:0] rh);
        logic [31:0] adc_t, adc_p, adc_h;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, tf, p, v, q, tc;
        reading_t r;
        adc_t = {12'd0, rt};
        adc_p = {12'd0, rp};
        adc_h = {16'd0, rh};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {16'd0, cal_plo[15:0]};
        p2 = {{16{cal_plo[31]}}, cal_plo[31:16]};
        p3 = {{16{cal_plo[47]}}, cal_plo[47:32]};
        p4 = {{16{cal_plo[63]}}, cal_plo[63:48]};
        p5 = {{16{cal_phi[15]}}, cal_phi[15:0]};
        p6 = {{16{cal_phi[31]}}, cal_phi[31:16]};
        p7 = {{16{cal_phi[47]}}, cal_phi[47:32]};
        p8 = {{16{cal_phi[63]}}, cal_phi[63:48]};
        p9 = {{16{cal_plast[15]}}, cal_plast};
        h1 = {24'd0, cal_hum[7:0]};
        h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
        h3 = {24'd0, cal_hum[31:24]};
        h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
        h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
        h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

        // fine temperature
        a = sar(mlo((adc_t >> 3) - (t1 << 1), t2), 11);
        d = (adc_t >> 4) - t1;
        b = sar(mlo(sar(mlo(d, d), 12), t3), 14);
        tf = a + b;
        tc = sar(mlo(tf, 32'd5) + 32'd128, 8);
        r.temp = tc[23:0];

        // pressure, zero divisor flagged
        a = sar(tf, 1) - 32'd64000;
        d = sar(a, 2);
        b = mlo(sar(mlo(d, d), 11), p6);
        b = b + (mlo(a, p5) << 1);
        b = sar(b, 2) + (p4 << 16);
        a = sar(sar(mlo(p3, sar(mlo(d, d), 13)), 3) + sar(mlo(p2, a), 1), 18);
        a = sar(mlo(32'd32768 + a, p1), 15);
        if (a == 32'd0) begin
            p = 32'd0;
            r.inv = 1'b1;
        end else begin
            r.inv = 1'b0;
            p = mlo((32'd1048576 - adc_p) - sar(b, 12), 32'd3125);
            if (p < 32'h80000000) begin
                p = (p << 1) / a;
            end else begin
                p = (p / a) * 32'd2;
            end
            q = p >> 3;
            a = sar(mlo(p9, mlo(q, q) >> 13), 12);
            b = sar(mlo(p >> 2, p8), 13);
            p = p + sar(a + b + p7, 4);
        end
        r.press = p;

        // humidity, clamped before the final shift
        v = tf - 32'd76800;
        a = sar(((adc_h << 14) - (h4 << 20) - mlo(h5, v)) + 32'd16384, 15);
        b = sar(mlo(sar(mlo(v, h6), 10), sar(mlo(v, h3), 11) + 32'd32768), 10) + 32'd2097152;
        b = sar(mlo(b, h2) + 32'd8192, 14);
        v = mlo(a, b);
        d = sar(v, 15);
        v = v - sar(mlo(sar(mlo(d, d), 7), h1), 4);
        if (v[31]) begin
            v = 32'd0;
        end
        if (v > HUM_MAX) begin
            v = HUM_MAX;
        end
        r.hum = v[28:12];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // check each result item against the oldest expectation, stall at random
    always @(posedge aclk) begin
        reading_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result item with no expectation", $realtime);
                errors++;
            end else begin
                e = pending_readings.pop_front();
                if (m_tdata[23:0] !== e.temp)
                    report_mismatch("temp_centi", 32'(m_tdata[23:0]), 32'(e.temp));
                if (m_tdata[55:24] !== e.press)
                    report_mismatch("press_pa", m_tdata[55:24], e.press);
                if (m_tdata[72:56] !== e.hum)
                    report_mismatch("hum_q10", 32'(m_tdata[72:56]), 32'(e.hum));
                if (m_tuser[0] !== e.inv)
                    report_mismatch("press_invalid", 32'(m_tuser[0]), 32'(e.inv));
            end
        end
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp,
                                input logic [15:0] rh);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rh, rp, rt};
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(compensate(rt, rp, rh));
    endtask

    // hold off until every result is in and the pipeline is empty
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP_CAL:       cal_temp = val[47:0];
            REG_PRESS_CAL_LO:   cal_plo = val;
            REG_PRESS_CAL_HI:   cal_phi = val;
            REG_PRESS_CAL_LAST: cal_plast = val[15:0];
            REG_HUM_CAL:        cal_hum = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // typical factory calibration, optionally jittered
    task automatic load_typical(input bit jitter);
        logic [63:0] j;
        j = jitter ? {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF : '0;
        write_cal(REG_TEMP_CAL, {16'hFC18, 16'd26435, 16'd27504} ^ j);
        write_cal(REG_PRESS_CAL_LO, {16'd2855, 16'd3024, 16'hD643, 16'd36477} ^ j);
        write_cal(REG_PRESS_CAL_HI, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140} ^ j);
        write_cal(REG_PRESS_CAL_LAST, {48'hABCD_1234_5678, 16'd6000} ^ j);
        write_cal(REG_HUM_CAL, {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75} ^ j);
    endtask

    task automatic send_mixed;
        if ($urandom_range(3) == 0) begin
            send_reading(20'($urandom), 20'($urandom), 16'($urandom));
        end else begin
            send_reading(20'(20'd519888 + $urandom_range(65535) - 20'd32768),
                         20'(20'd415148 + $urandom_range(131071) - 20'd65536),
                         16'($urandom_range(65535)));
        end
    endtask

    // zero calibration after reset gives a zero divisor
    task automatic test_reset_cal;
        send_reading('0, '0, '0);
        send_reading('1, '1, '1);
        send_reading(20'd519888, 20'd415148, 16'd30000);
        drain();
    endtask

    task automatic test_directed;
        load_typical(1'b0);
        // index past the register list is ignored
        write_cal(3'd5, '1);
        write_cal(3'd7, '1);
        send_reading('0, '0, '0);
        send_reading('1, '1, '1);
        send_reading('0, '1, '0);
        send_reading('1, '0, '1);
        send_reading(20'd519888, 20'd415148, 16'd30000);
        send_reading(20'd519888, 20'd415148, 16'd0);
        send_reading(20'd519888, 20'd415148, 16'hFFFF);
        drain();
        // all-ones calibration words
        write_cal(REG_TEMP_CAL, '1);
        write_cal(REG_PRESS_CAL_LO, '1);
        write_cal(REG_PRESS_CAL_HI, '1);
        write_cal(REG_PRESS_CAL_LAST, '1);
        write_cal(REG_HUM_CAL, '1);
        send_reading('0, '0, '0);
        send_reading('1, '1, '1);
        send_reading(20'h80000, 20'h80000, 16'h8000);
        drain();
        // only the pressure scale zeroed: divisor zero with sane temperature
        load_typical(1'b0);
        write_cal(REG_PRESS_CAL_LO, {16'd2855, 16'd3024, 16'hD643, 16'd0});
        send_reading(20'd519888, 20'd415148, 16'd30000);
        send_reading(20'($urandom), 20'($urandom), 16'($urandom));
        drain();
    endtask

    task automatic test_random(input int rounds);
        repeat (rounds) begin
            case ($urandom_range(3))
                0: begin
                    write_cal(REG_TEMP_CAL, {$urandom, $urandom});
                    write_cal(REG_PRESS_CAL_LO, {$urandom, $urandom});
                    write_cal(REG_PRESS_CAL_HI, {$urandom, $urandom});
                    write_cal(REG_PRESS_CAL_LAST, {$urandom, $urandom});
                    write_cal(REG_HUM_CAL, {$urandom, $urandom});
                end
                1: load_typical(1'b0);
                default: load_typical(1'b1);
            endcase
            repeat (90) send_mixed();
            drain();
        end
    endtask

    // sender waits for every result before going on
    task automatic test_pause;
        load_typical(1'b1);
        repeat (20) send_mixed();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
        repeat (20) send_mixed();
        drain();
    endtask

    initial begin
        cal_temp = '0;
        cal_plo = '0;
        cal_phi = '0;
        cal_plast = '0;
        cal_hum = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle = 6;
        rcv_idle = 71;
        test_reset_cal();
        test_directed();
        test_random(4);
        snd_idle = 71;
        rcv_idle = 6;
        test_random(4);
        test_pause();
        snd_idle = 0;
        rcv_idle = 0;
        test_random(4);

        drain();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/esc_pkg.sv
rtl/core/esc_div.sv
rtl/core/env_sensor_compensation.sv
tb/tb.sv
